>>> src/rbfk_pkg.sv
// Shared types and constants for the RBF kernel evaluator.
// Used by the controller, the datapath and the top level; depends on nothing.
package rbfk_pkg;

    localparam int SUM_WIDTH = 48;
    localparam int X_WIDTH   = 64;
    localparam int T_WIDTH   = 31;
    localparam int R_WIDTH   = 26;

    localparam logic [15:0]          GAMMA_RESET = 16'd4096;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX     = {SUM_WIDTH{1'b1}};
    localparam logic [T_WIDTH-1:0]   Q30_ONE     = 31'h4000_0000;
    localparam logic [X_WIDTH-1:0]   EXP_LIMIT   = 64'd12 << 28;
    // Exact floor(p/3) for any 32-bit p: (p * DIV3_RECIP) >> 33.
    localparam logic [31:0]          DIV3_RECIP  = 32'hAAAA_AAAB;

    localparam int NUM_SQUARES = 8;

    // Taylor term divisors of the nested polynomial.
    localparam logic [1:0] TERM_THIRD = 2'd3;
    localparam logic [1:0] TERM_HALF  = 2'd2;
    localparam logic [1:0] TERM_UNIT  = 2'd1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MUL_XLO,
        OP_MUL_XHI,
        OP_XSUM,
        OP_RANGE,
        OP_MUL_RT,
        OP_MUL_DIV3,
        OP_T_UPD,
        OP_MUL_SQ,
        OP_SQ_UPD,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic       load;
        t_dp_op     op;
        logic [1:0] term;
    } t_dp_cmd;

    typedef struct packed {
        logic x_big;
    } t_dp_status;

endpackage

>>> src/rbfk_ctrl.sv
// Sequencer for the RBF kernel evaluator: input handshake and the step
// order of the exponential. Depends on rbfk_pkg.
module rbfk_ctrl
    import rbfk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic       i_last,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FILL,
        S_XLO,
        S_XHI,
        S_XSUM,
        S_RANGE,
        S_MULRT,
        S_DIV3,
        S_TUPD,
        S_SQ,
        S_SQUPD,
        S_DONE
    } t_state;

    localparam logic [2:0] SQ_LAST = 3'(NUM_SQUARES - 1);

    t_state     r_state;
    logic       r_busy;
    logic [1:0] r_term;
    logic [2:0] r_sq_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_term   <= TERM_THIRD;
            r_sq_cnt <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start && i_last) begin
                        r_state <= S_FILL;
                        r_busy  <= 1'b1;
                    end
                end
                S_FILL:  r_state <= S_XLO;
                S_XLO:   r_state <= S_XHI;
                S_XHI:   r_state <= S_XSUM;
                S_XSUM:  r_state <= S_RANGE;
                S_RANGE: begin
                    r_term   <= TERM_THIRD;
                    r_sq_cnt <= '0;
                    r_state  <= i_status.x_big ? S_DONE : S_MULRT;
                end
                S_MULRT: r_state <= (r_term == TERM_THIRD) ? S_DIV3 : S_TUPD;
                S_DIV3:  r_state <= S_TUPD;
                S_TUPD: begin
                    if (r_term == TERM_UNIT) begin
                        r_state <= S_SQ;
                    end else begin
                        r_term  <= r_term - 2'd1;
                        r_state <= S_MULRT;
                    end
                end
                S_SQ:    r_state <= S_SQUPD;
                S_SQUPD: begin
                    if (r_sq_cnt == SQ_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_sq_cnt <= r_sq_cnt + 3'd1;
                        r_state  <= S_SQ;
                    end
                end
                S_DONE: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_busy  <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.load = i_start && !r_busy;
        o_cmd.term = r_term;
        unique case (r_state)
            S_XLO:   o_cmd.op = OP_MUL_XLO;
            S_XHI:   o_cmd.op = OP_MUL_XHI;
            S_XSUM:  o_cmd.op = OP_XSUM;
            S_RANGE: o_cmd.op = OP_RANGE;
            S_MULRT: o_cmd.op = OP_MUL_RT;
            S_DIV3:  o_cmd.op = OP_MUL_DIV3;
            S_TUPD:  o_cmd.op = OP_T_UPD;
            S_SQ:    o_cmd.op = OP_MUL_SQ;
            S_SQUPD: o_cmd.op = OP_SQ_UPD;
            S_DONE:  o_cmd.op = OP_EMIT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_busy = r_busy;

endmodule

>>> src/rbfk_datapath.sv
// Datapath of the RBF kernel evaluator: squared-difference accumulator,
// gamma register and the shared multiplier of the exponential. Depends on rbfk_pkg.
module rbfk_datapath
    import rbfk_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_dp_cmd                         i_cmd,
    output t_dp_status                      o_status,
    input  logic                            i_cfg_we,
    input  logic [15:0]                     i_cfg_wdata,
    input  logic signed [ELEMENT_WIDTH-1:0] i_first_element,
    input  logic signed [ELEMENT_WIDTH-1:0] i_second_element,
    input  logic                            i_last_element,
    output logic [15:0]                     o_kernel_value,
    output logic                            o_sum_saturated,
    output logic                            o_result_strobe
);

    localparam int EW = ELEMENT_WIDTH;

    logic [15:0] r_gamma;

    // Input stage: squared difference of one beat.
    logic signed [EW:0]     diff;
    logic [EW:0]            mag;
    logic [32:0]            mag_ext;
    logic                   sq_big;
    logic [SUM_WIDTH-1:0]   n_sq;

    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic                   r_s1_big;
    logic [SUM_WIDTH-1:0]   r_s1_sq;

    logic [SUM_WIDTH-1:0]   r_sum;
    logic                   r_ovf;
    logic [SUM_WIDTH:0]     total;
    logic [SUM_WIDTH-1:0]   n_sum;
    logic                   n_ovf;

    logic [SUM_WIDTH-1:0]   r_dist;
    logic                   r_dist_ovf;

    // Exponential registers.
    logic [X_WIDTH-1:0]     r_prod;
    logic [X_WIDTH-1:0]     r_x;
    logic [R_WIDTH-1:0]     r_r;
    logic [T_WIDTH-1:0]     r_t;

    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [X_WIDTH-1:0]     n_prod;
    logic [R_WIDTH-1:0]     r_from_x;
    logic [T_WIDTH-1:0]     quot;
    logic [16:0]            t_scaled;

    assign diff    = {i_first_element[EW-1], i_first_element}
                   - {i_second_element[EW-1], i_second_element};
    assign mag     = diff[EW] ? (~diff + 1'b1) : diff;
    assign mag_ext = 33'(mag);
    assign sq_big  = |mag_ext[32:24];
    assign n_sq    = 48'(mag_ext[23:0]) * 48'(mag_ext[23:0]);

    assign total = {1'b0, r_sum} + {1'b0, r_s1_sq};
    always_comb begin
        if (r_s1_big || total[SUM_WIDTH]) begin
            n_sum = SUM_MAX;
            n_ovf = 1'b1;
        end else begin
            n_sum = total[SUM_WIDTH-1:0];
            n_ovf = r_ovf;
        end
    end

    assign r_from_x       = r_x[31:6];
    assign o_status.x_big = (r_x >= EXP_LIMIT);

    always_comb begin
        unique case (i_cmd.op)
            OP_MUL_XLO: begin
                mul_a = 32'(r_gamma);
                mul_b = 32'(r_dist[23:0]);
            end
            OP_MUL_XHI: begin
                mul_a = 32'(r_gamma);
                mul_b = 32'(r_dist[47:24]);
            end
            OP_MUL_RT: begin
                mul_a = 32'(r_r);
                mul_b = 32'(r_t);
            end
            OP_MUL_DIV3: begin
                mul_a = r_prod[61:30];
                mul_b = DIV3_RECIP;
            end
            OP_MUL_SQ: begin
                mul_a = 32'(r_t);
                mul_b = 32'(r_t);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign n_prod = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        unique case (i_cmd.term)
            TERM_THIRD: quot = r_prod[63:33];
            TERM_HALF:  quot = {1'b0, r_prod[60:31]};
            TERM_UNIT:  quot = r_prod[60:30];
            default:    quot = '0;
        endcase
    end

    assign t_scaled = r_t[30:14];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamma         <= GAMMA_RESET;
            r_s1_valid      <= 1'b0;
            r_sum           <= '0;
            r_ovf           <= 1'b0;
            o_result_strobe <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gamma <= i_cfg_wdata;
            end
            r_s1_valid <= i_cmd.load;
            if (r_s1_valid) begin
                if (r_s1_last) begin
                    r_sum <= '0;
                    r_ovf <= 1'b0;
                end else begin
                    r_sum <= n_sum;
                    r_ovf <= n_ovf;
                end
            end
            o_result_strobe <= (i_cmd.op == OP_EMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_s1_sq   <= n_sq;
            r_s1_big  <= sq_big;
            r_s1_last <= i_last_element;
        end
        if (r_s1_valid && r_s1_last) begin
            r_dist     <= n_sum;
            r_dist_ovf <= n_ovf;
        end

        unique case (i_cmd.op)
            OP_MUL_XLO, OP_MUL_RT, OP_MUL_DIV3, OP_MUL_SQ: r_prod <= n_prod;
            OP_MUL_XHI: begin
                r_x    <= r_prod;
                r_prod <= n_prod;
            end
            OP_XSUM:   r_x <= r_x + (r_prod << 24);
            OP_RANGE: begin
                r_r <= r_from_x;
                // An out-of-range exponent forces the result to zero.
                r_t <= o_status.x_big ? '0 : (Q30_ONE - T_WIDTH'(r_from_x >> 2));
            end
            OP_T_UPD:  r_t <= Q30_ONE - quot;
            OP_SQ_UPD: r_t <= r_prod[60:30];
            OP_EMIT: begin
                o_kernel_value  <= t_scaled[16] ? 16'hFFFF : t_scaled[15:0];
                o_sum_saturated <= r_dist_ovf;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> src/rbf_kernel_evaluator_top.sv
// Gaussian RBF kernel evaluator, top level: controller and datapath.
// Depends on rbfk_pkg, rbfk_ctrl and rbfk_datapath.
//
// Element pairs are taken one per clock while busy is low; a beat is taken at
// an edge where start is high and busy is low. The beat flagged last raises
// busy, and the kernel value appears on o_kernel_value with o_result_strobe for
// one cycle; it is zero when gamma times the distance is 12.0 or more, and the
// polynomial and squarings are then skipped. Busy drops in the strobe cycle, so
// the next vector may start there. The exponential runs gamma times distance,
// range reduction, its polynomial and eight squarings, all but range reduction
// on one shared 32x32 multiplier. Results cannot be held off: the
// receiver must take the strobe cycle. Gamma may be written at any idle time.
module rbf_kernel_evaluator_top
    import rbfk_pkg::*;
#(
    parameter int ELEMENT_WIDTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_cfg_we,
    input  logic [15:0]                     i_cfg_wdata,
    input  logic signed [ELEMENT_WIDTH-1:0] i_first_element,
    input  logic signed [ELEMENT_WIDTH-1:0] i_second_element,
    input  logic                            i_last_element,
    output logic [15:0]                     o_kernel_value,
    output logic                            o_sum_saturated,
    output logic                            o_result_strobe
);

    t_dp_cmd    cmd;
    t_dp_status status;

    rbfk_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_last   (i_last_element),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    rbfk_datapath #(
        .ELEMENT_WIDTH (ELEMENT_WIDTH)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_first_element  (i_first_element),
        .i_second_element (i_second_element),
        .i_last_element   (i_last_element),
        .o_kernel_value   (o_kernel_value),
        .o_sum_saturated  (o_sum_saturated),
        .o_result_strobe  (o_result_strobe)
    );

endmodule

>>> src/rbfk_checker.sv
// Port-level checks for the RBF kernel evaluator, bound to the top level.
// Depends on rbf_kernel_evaluator_top port names only.
module rbfk_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last_element,
    input logic o_result_strobe
);

    // A result beat ends a busy span.
    a_strobe_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (!busy && $past(busy)))
        else $error("result strobe without a preceding busy span");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe held for more than one cycle");

    a_last_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last_element) |=> busy)
        else $error("last beat did not raise busy");

    a_mid_keeps_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last_element) |=> !busy)
        else $error("busy rose after a beat that was not last");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start && i_last_element))
        else $error("busy rose without an accepted last beat");

endmodule

bind rbf_kernel_evaluator_top rbfk_checker u_rbfk_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_last_element  (i_last_element),
    .o_result_strobe (o_result_strobe)
);
